[sv/rae_pkg.sv]
`default_nettype none

package rae_pkg;

    localparam int unsigned LEN_W   = 6;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned RES_MAX = 3;

    localparam logic [LEN_W-1:0]  MAX_ARG_LEN   = 6'd63;
    localparam logic [SLOT_W-1:0] CAPTURED_ARGS = 2'd3;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_MSG_END = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        out_byte;
        logic [LEN_W-1:0]  arg_length;
        logic              truncated;
        logic [1:0]        args_found;
        logic              run_last;
    } t_result;

    // results caused by one byte, oldest in entry 0
    typedef struct packed {
        logic [1:0]                cnt;
        t_result [RES_MAX-1:0]     res;
    } t_res_set;

endpackage

`default_nettype wire

[sv/rae_parser.sv]
`default_nettype none

module rae_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output rae_pkg::t_res_set       o_set
);
    import rae_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT_STAR,
        PH_HEADER,
        PH_ITEM,
        PH_LENLINE,
        PH_DATA,
        PH_STOPPED
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_cr, n_cr;
    logic [SLOT_W-1:0]  r_arg, n_arg;
    logic [LEN_W-1:0]   r_kept, n_kept;
    logic               r_ovf, n_ovf;
    t_res_set           set;

    function automatic t_result mk(input logic [1:0] kind, input logic [SLOT_W-1:0] slot,
                                   input logic [7:0] b, input logic [LEN_W-1:0] len,
                                   input logic trunc, input logic [1:0] found);
        t_result r;
        r.kind       = kind;
        r.slot       = slot;
        r.out_byte   = b;
        r.arg_length = len;
        r.truncated  = trunc;
        r.args_found = found;
        r.run_last   = 1'b0;
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_cr    = r_cr;
        n_arg   = r_arg;
        n_kept  = r_kept;
        n_ovf   = r_ovf;
        set     = '0;

        unique case (r_phase)
            PH_WAIT_STAR: begin
                n_phase = (i_byte == CH_STAR) ? PH_HEADER : PH_STOPPED;
            end
            PH_HEADER, PH_LENLINE: begin
                priority if (i_byte == CH_NUL) begin
                    n_phase = PH_STOPPED;
                    n_cr    = 1'b0;
                end else if (i_byte == CH_CR) begin
                    n_cr = 1'b1;
                end else if (i_byte == CH_LF && r_cr) begin
                    n_cr = 1'b0;
                    if (r_phase == PH_HEADER) begin
                        n_phase = PH_ITEM;
                    end else begin
                        n_phase = PH_DATA;
                        n_kept  = '0;
                        n_ovf   = 1'b0;
                    end
                end else begin
                    n_cr = 1'b0;
                end
            end
            PH_ITEM: begin
                n_phase = (i_byte == CH_DOLLAR) ? PH_LENLINE : PH_STOPPED;
            end
            PH_DATA: begin
                priority if (i_byte == CH_NUL) begin
                    n_phase = PH_STOPPED;
                    n_cr    = 1'b0;
                end else if (i_byte == CH_LF && r_cr) begin
                    n_cr = 1'b0;
                    if (r_arg < CAPTURED_ARGS) begin
                        set.res[set.cnt] = mk(KIND_ARG_END, r_arg, 8'd0, r_kept, r_ovf, 2'd0);
                        set.cnt          = set.cnt + 2'd1;
                        n_arg            = r_arg + 2'd1;
                    end
                    n_kept  = '0;
                    n_ovf   = 1'b0;
                    n_phase = PH_ITEM;
                end else begin
                    // a held cr that is not followed by lf is plain data
                    if (r_cr && r_arg < CAPTURED_ARGS) begin
                        if (n_kept < MAX_ARG_LEN) begin
                            set.res[set.cnt] = mk(KIND_BYTE, r_arg, CH_CR, '0, 1'b0, 2'd0);
                            set.cnt          = set.cnt + 2'd1;
                            n_kept           = n_kept + 6'd1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_byte == CH_CR) begin
                        n_cr = 1'b1;
                    end else begin
                        n_cr = 1'b0;
                        if (r_arg < CAPTURED_ARGS) begin
                            if (n_kept < MAX_ARG_LEN) begin
                                set.res[set.cnt] = mk(KIND_BYTE, r_arg, i_byte, '0, 1'b0,
                                                      2'd0);
                                set.cnt          = set.cnt + 2'd1;
                                n_kept           = n_kept + 6'd1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_STOPPED;
            end
        endcase

        if (i_last) begin
            set.res[set.cnt] = mk(KIND_MSG_END, '0, 8'd0, '0, 1'b0,
                                  (r_arg < CAPTURED_ARGS) ? n_arg : CAPTURED_ARGS);
            set.cnt = set.cnt + 2'd1;
            n_phase = PH_WAIT_STAR;
            n_cr    = 1'b0;
            n_arg   = '0;
            n_kept  = '0;
            n_ovf   = 1'b0;
        end

        if (set.cnt != 2'd0) begin
            set.res[set.cnt - 2'd1].run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_STAR;
            r_cr    <= 1'b0;
            r_arg   <= '0;
            r_kept  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_arg   <= n_arg;
            r_kept  <= n_kept;
            r_ovf   <= n_ovf;
        end
    end

    assign o_set = set;

`ifndef ASSERT_OFF
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last |=> r_phase == PH_WAIT_STAR && !r_cr && r_arg == '0 && r_kept == '0)
        else $error("state not cleared after message end");

    a_three_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && set.cnt == 2'd3 |-> i_last)
        else $error("three results without message end");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_phase) && $stable(r_kept) && $stable(r_arg))
        else $error("parser state moved without a byte");
`endif

endmodule

`default_nettype wire

[sv/rae_result_buf.sv]
`default_nettype none

module rae_result_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire rae_pkg::t_res_set  i_set,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output rae_pkg::t_result        o_res,
    output logic                    o_free
);
    import rae_pkg::*;

    t_result [RES_MAX-1:0] r_res;
    logic [1:0]            r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_res[0];
    // can reload when empty or the last held result leaves this cycle
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_set.cnt;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_set.res;
        end else if (o_valid && i_ready) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

`ifndef ASSERT_OFF
    a_last_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> (r_res[0].run_last == (r_cnt == 2'd1)))
        else $error("run_last not on final buffered result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready))
        else $error("result buffer overwritten");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load && o_valid && i_ready |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("result count did not drop on take");
`endif

endmodule

`default_nettype wire

[sv/resp_array_arg_extractor_unit.sv]
`default_nettype none

// path: input register, then result buffer, which drives the master side
// throughput: one byte per cycle while each byte gives at most one result word
// and m_axis_tready is high; a byte giving k words (up to 3) holds the buffer until
// all k are taken; bytes with no result pass at one per cycle if the buffer is free
// reset: synchronous, active low; clears parser state and both stage valids
module resp_array_arg_extractor_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // msg_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [1:0] slot, [9:2] out_byte,
                                             // [15:10] arg_length, [16] truncated,
                                             // [18:17] args_found, [23:19] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // run_last
);
    import rae_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       take;
    logic       buf_free;
    t_res_set   set;
    t_result    head;

    assign take          = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= (s_axis_tvalid && s_axis_tready) || (r_in_valid && !take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    rae_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_set   (set)
    );

    rae_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_set   (set),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (head),
        .o_free  (buf_free)
    );

    assign m_axis_tdata = {5'd0, head.args_found, head.truncated, head.arg_length,
                           head.out_byte, head.slot};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.run_last;

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !take |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input word lost while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty register");

    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !(s_axis_tvalid && s_axis_tready) |=> !r_in_valid)
        else $error("input register not emptied after take");
`endif

endmodule

`default_nettype wire

[test/rae_arg_check.sv]
`default_nettype none

module rae_arg_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_tlast,   // msg_last
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // [1:0] slot, [9:2] out_byte, [15:10] arg_length,
                                          // [16] truncated, [18:17] args_found, [23:19] zero
    input  wire logic [1:0]  i_m_tuser,   // [1:0] kind
    input  wire logic        i_m_tlast,   // run_last
    output int               o_fail_count,
    output int               o_words_due,
    output int               o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rae_pkg::*;

    typedef enum logic [2:0] {
        P_AWAIT_STAR,
        P_HEADER,
        P_ITEM,
        P_LEN_LINE,
        P_DATA,
        P_STOPPED
    } t_parse_phase;

    t_parse_phase       phase = P_AWAIT_STAR;
    logic               cr_held = 1'b0;
    logic [SLOT_W-1:0]  arg_idx = '0;
    logic [LEN_W-1:0]   kept_len = '0;
    logic               overflow = 1'b0;

    t_result            burst[$];
    t_result            arg_words_due[$];
    int                 fail_total = 0;
    int                 words_checked = 0;

    task automatic clear_parser();
        phase    = P_AWAIT_STAR;
        cr_held  = 1'b0;
        arg_idx  = '0;
        kept_len = '0;
        overflow = 1'b0;
    endtask

    task automatic add_word(input logic [1:0] kind, input logic [SLOT_W-1:0] slot,
                            input logic [7:0] data, input logic [LEN_W-1:0] len,
                            input logic trunc, input logic [1:0] found);
        t_result w;
        w.kind       = kind;
        w.slot       = slot;
        w.out_byte   = data;
        w.arg_length = len;
        w.truncated  = trunc;
        w.args_found = found;
        w.run_last   = 1'b0;
        burst.push_back(w);
    endtask

    // bytes past the kept length only raise the truncation flag
    task automatic keep_data_byte(input logic [7:0] data);
        if (arg_idx < CAPTURED_ARGS) begin
            if (kept_len < MAX_ARG_LEN) begin
                add_word(KIND_BYTE, arg_idx, data, '0, 1'b0, 2'd0);
                kept_len = kept_len + 1'b1;
            end else begin
                overflow = 1'b1;
            end
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b, input logic last);
        t_result w;
        burst.delete();
        case (phase)
            P_AWAIT_STAR: phase = (b == CH_STAR) ? P_HEADER : P_STOPPED;
            P_HEADER, P_LEN_LINE: begin
                if (b == CH_NUL) begin
                    phase   = P_STOPPED;
                    cr_held = 1'b0;
                end else if (b == CH_CR) begin
                    cr_held = 1'b1;
                end else if (b == CH_LF && cr_held) begin
                    cr_held = 1'b0;
                    if (phase == P_HEADER) begin
                        phase = P_ITEM;
                    end else begin
                        phase    = P_DATA;
                        kept_len = '0;
                        overflow = 1'b0;
                    end
                end else begin
                    cr_held = 1'b0;
                end
            end
            P_ITEM: phase = (b == CH_DOLLAR) ? P_LEN_LINE : P_STOPPED;
            P_DATA: begin
                if (b == CH_NUL) begin
                    phase   = P_STOPPED;
                    cr_held = 1'b0;
                end else if (b == CH_LF && cr_held) begin
                    cr_held = 1'b0;
                    if (arg_idx < CAPTURED_ARGS) begin
                        add_word(KIND_ARG_END, arg_idx, 8'd0, kept_len, overflow, 2'd0);
                        arg_idx = arg_idx + 1'b1;
                    end
                    kept_len = '0;
                    overflow = 1'b0;
                    phase    = P_ITEM;
                end else begin
                    // a held cr not followed by lf is plain data
                    if (cr_held)
                        keep_data_byte(CH_CR);
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else begin
                        cr_held = 1'b0;
                        keep_data_byte(b);
                    end
                end
            end
            default: phase = P_STOPPED;
        endcase

        if (last) begin
            add_word(KIND_MSG_END, '0, 8'd0, '0, 1'b0, arg_idx);
            clear_parser();
        end

        foreach (burst[i]) begin
            w = burst[i];
            w.run_last = (i == burst.size() - 1);
            arg_words_due.push_back(w);
        end
    endtask

    task automatic report_fail(input string msg);
        $display("[%0t] result word %0d: %s", $realtime, words_checked, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_fail($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    task automatic check_word();
        t_result w;
        if (arg_words_due.size() == 0) begin
            report_fail($sformatf("unexpected word, tuser %0d tdata %h",
                                  i_m_tuser, i_m_tdata));
        end else begin
            w = arg_words_due.pop_front();
            check_field("kind",       w.kind,       i_m_tuser);
            check_field("slot",       w.slot,       i_m_tdata[1:0]);
            check_field("out_byte",   w.out_byte,   i_m_tdata[9:2]);
            check_field("arg_length", w.arg_length, i_m_tdata[15:10]);
            check_field("truncated",  w.truncated,  i_m_tdata[16]);
            check_field("args_found", w.args_found, i_m_tdata[18:17]);
            check_field("run_last",   w.run_last,   i_m_tlast);
            check_field("padding",    0,            i_m_tdata[23:19]);
        end
        words_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            arg_words_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                parse_rx_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_word();
        end
        o_words_due     <= arg_words_due.size();
        o_fail_count    <= fail_total;
        o_words_checked <= words_checked;
    end

endmodule

`default_nettype wire

[test/tb_resp_array_arg_extractor_unit.sv]
`default_nettype none

module tb_resp_array_arg_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rae_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 270;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] rx_byte
    logic        s_axis_tlast = 1'b0;    // msg_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [1:0] slot, [9:2] out_byte, [15:10] arg_length,
                                         // [16] truncated, [18:17] args_found, [23:19] zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;           // run_last

    int          fail_count;
    int          words_due;
    int          words_checked;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          msgs_sent = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    logic [7:0]  msg_q[$];

    resp_array_arg_extractor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rae_arg_check u_arg_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tlast       (s_axis_tlast),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due),
        .o_words_checked (words_checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count, words_due);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= 26);

    task automatic put_text(input string s);
        foreach (s[i])
            msg_q.push_back(s[i]);
    endtask

    task automatic put_crlf();
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while (tx_idle_on && $urandom_range(99) < 26) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_msg();
        int i;
        for (i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        msg_q.delete();
        msgs_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (words_due != 0)
            @(posedge i_clk);
    endtask

    // '$', length line (sometimes a wrong length), data, crlf
    task automatic build_arg(input int len);
        int i;
        int r;
        msg_q.push_back(CH_DOLLAR);
        put_text($sformatf("%0d", ($urandom_range(99) < 10) ? $urandom_range(0, 99) : len));
        put_crlf();
        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 6)
                msg_q.push_back(CH_CR);
            else if (r < 10)
                msg_q.push_back(CH_LF);
            else
                msg_q.push_back(8'($urandom_range(1, 255)));
        end
        put_crlf();
    endtask

    task automatic build_request(input int nargs, input int long_idx);
        int i;
        int len;
        int r;
        msg_q.push_back(CH_STAR);
        put_text($sformatf("%0d", nargs));
        if ($urandom_range(99) < 10) begin
            msg_q.push_back(CH_CR);
            put_text("x");
        end
        put_crlf();
        for (i = 0; i < nargs; i++) begin
            if (i == long_idx)
                len = 64;
            else if ($urandom_range(99) < 4)
                len = 61 + $urandom_range(0, 9);
            else
                len = $urandom_range(0, 8);
            build_arg(len);
        end
        if (long_idx < 0) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // cut short, possibly mid argument
                repeat ($urandom_range(1, msg_q.size() - 1))
                    void'(msg_q.pop_back());
            end else if (r < 13) begin
                msg_q.insert($urandom_range(1, msg_q.size() - 1), CH_NUL);
            end else if (r < 18) begin
                put_text("+OK");
                put_crlf();
            end
        end
    endtask

    task automatic build_noise();
        int i;
        int n;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
            msg_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(99) < 30)
            msg_q[0] = CH_STAR;
    endtask

    initial begin
        int random_start;
        int sent_here;
        bit paused;
        bit first;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // message without a leading star
        msg_q.push_back(8'hFF);
        send_msg();

        // lone cr, cr cr and a top-value data byte
        msg_q.push_back(CH_STAR);
        put_crlf();
        msg_q.push_back(CH_DOLLAR);
        put_crlf();
        msg_q.push_back(CH_CR);
        put_text("B");
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_CR);
        msg_q.push_back(8'hFF);
        put_crlf();
        send_msg();

        // item not starting with '$'
        msg_q.push_back(CH_STAR);
        put_crlf();
        put_text("#");
        send_msg();

        // zero byte inside an argument
        msg_q.push_back(CH_STAR);
        put_crlf();
        msg_q.push_back(CH_DOLLAR);
        put_crlf();
        put_text("Q");
        msg_q.push_back(CH_NUL);
        put_text("z");
        send_msg();

        hold_until_drained();

        random_start = bytes_sent;
        paused = 1'b0;
        first = 1'b1;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            sent_here = bytes_sent - random_start;
            tx_idle_on = !(sent_here >= 100 && sent_here < 180);
            rx_idle_on = tx_idle_on;
            if (!paused && sent_here >= 150) begin
                hold_until_drained();
                paused = 1'b1;
            end
            // first request: extra arguments and one past the kept length
            if (first)
                build_request(4, 1);
            else if ($urandom_range(99) < 75)
                build_request($urandom_range(0, 5), -1);
            else
                build_noise();
            first = 1'b0;
            send_msg();
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_until_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes in %0d messages, %0d result words compared",
                 bytes_sent, msgs_sent, words_checked);
        $display("directed edge cases, then requests, broken requests and noise with stalls");
        if (fail_count == 0 && words_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
